### sv/tiered_sliding_window_counter_top_macros.svh
// Assertion macros for the tiered sliding-window counter.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef TIERED_SLIDING_WINDOW_COUNTER_TOP_MACROS_SVH
`define TIERED_SLIDING_WINDOW_COUNTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TSWC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tswc assertion failed");
`define TSWC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tswc assertion failed");
`else
`define TSWC_ASSERT(lbl, prop)
`define TSWC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### sv/tswc_pkg.sv
// Shared types and constants of the tiered sliding-window counter.
// No dependencies.
package tswc_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned DeltaW   = 16;
  localparam int unsigned CountW   = 32;
  localparam int unsigned PAddrW   = 3;
  localparam int unsigned PDataW   = 32;

  localparam logic [TimeW-1:0] SecPerMin  = 32'd60;
  localparam logic [TimeW-1:0] SecPerHour = 32'd3600;
  // reciprocals: floor(e * Recip >> Shift) is exact for every 32-bit e
  localparam logic [TimeW-1:0] RecipMin   = 32'h8888_8889;
  localparam logic [TimeW-1:0] RecipHour  = 32'h91A2_B3C5;
  localparam int unsigned      ShiftMin   = 37;
  localparam int unsigned      ShiftHour  = 43;

  localparam logic [0:0] RegStartTime = 1'b0;

  typedef enum logic [1:0] {
    TierSec,
    TierMin,
    TierHr
  } tier_e;

  typedef enum logic [3:0] {
    StIdle,
    StDivLd,
    StDivRun,
    StAgeInit,
    StClrRd,
    StClrWr,
    StSpRd,
    StSpWr,
    StNextTier,
    StDlRd,
    StDlWr,
    StDone
  } state_e;

  typedef struct packed {
    logic  ld;
    logic  div_ld;
    logic  div_step;
    logic  age_init;
    logic  clr_rd;
    logic  clr_wr;
    logic  sp_rd;
    logic  sp_wr;
    logic  dl_rd;
    logic  dl_wr;
    logic  out_ld;
    tier_e tier;
  } ctrl_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic cnt_last;
  } ctrl_stat_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic rot;
  } ring_cmd_t;

  typedef struct packed {
    logic              we;
    logic [TimeW-1:0]  wdata;
  } cfg_wr_t;

endpackage

### sv/tswc_ring.sv
// One slot ring: memory with rotating head, per-entry valid bits, running total.
// Depends on tswc_pkg.
module tswc_ring #(
  parameter int unsigned D = 60
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tswc_pkg::ring_cmd_t        cmd_i,
  input  logic [$clog2(D)-1:0]       off_i,
  input  logic [$clog2(D)-1:0]       rot_i,
  input  logic [tswc_pkg::CountW-1:0] wdata_i,
  output logic [tswc_pkg::CountW-1:0] rdata_o,
  output logic [tswc_pkg::CountW-1:0] total_o
);

  localparam int unsigned IW = $clog2(D);
  localparam logic [IW:0] DepthC = (IW+1)'(D);

  logic [tswc_pkg::CountW-1:0] mem_q [D];
  logic [tswc_pkg::CountW-1:0] rd_q;
  logic                        rvld_q;
  logic [D-1:0]                vld_q;
  logic [IW-1:0]               head_q, addr_q;
  logic [tswc_pkg::CountW-1:0] total_q;
  logic [IW:0]                 sum, head_rot;
  logic [IW-1:0]               addr;

  // logical slot -> physical entry
  always_comb begin
    sum = {1'b0, head_q} + {1'b0, off_i};
    if (sum >= DepthC) begin
      sum = sum - DepthC;
    end
    addr = sum[IW-1:0];
  end

  // moving the head back ages every slot by rot_i
  always_comb begin
    if (head_q >= rot_i) begin
      head_rot = {1'b0, head_q} - {1'b0, rot_i};
    end else begin
      head_rot = {1'b0, head_q} + DepthC - {1'b0, rot_i};
    end
  end

  assign rdata_o = rvld_q ? rd_q : '0;
  assign total_o = total_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr_q] <= wdata_i;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rvld_q  <= 1'b0;
      head_q  <= '0;
      addr_q  <= '0;
      total_q <= '0;
    end else begin
      if (cmd_i.rd) begin
        addr_q <= addr;
        rvld_q <= vld_q[addr];
      end
      if (cmd_i.wr) begin
        vld_q[addr_q] <= 1'b1;
        total_q       <= total_q - rdata_o + wdata_i;
      end
      if (cmd_i.rot) begin
        head_q <= head_rot[IW-1:0];
      end
    end
  end

endmodule

### sv/tswc_datapath.sv
// Datapath: time bases, reciprocal divider, three slot rings, output word.
// Depends on tswc_pkg and tswc_ring.
module tswc_datapath #(
  parameter int unsigned SECOND_SLOTS = 60,
  parameter int unsigned MINUTE_SLOTS = 60,
  parameter int unsigned HOUR_SLOTS   = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tswc_pkg::ctrl_cmd_t           cmd_i,
  output tswc_pkg::ctrl_stat_t          stat_o,
  input  tswc_pkg::cfg_wr_t             cfg_i,
  output logic [tswc_pkg::TimeW-1:0]    start_time_o,
  input  logic [tswc_pkg::TimeW-1:0]    timestamp_sec_i,
  input  logic [tswc_pkg::DeltaW-1:0]   delta_i,
  output logic [tswc_pkg::CountW-1:0]   minute_total_o,
  output logic [tswc_pkg::CountW-1:0]   hour_total_o,
  output logic [tswc_pkg::CountW-1:0]   day_total_o,
  output logic                          out_of_order_o
);

  localparam int unsigned TW  = tswc_pkg::TimeW;
  localparam int unsigned CNW = tswc_pkg::CountW;
  localparam int unsigned MaxSM = (SECOND_SLOTS > MINUTE_SLOTS) ? SECOND_SLOTS : MINUTE_SLOTS;
  localparam int unsigned MaxD  = (MaxSM > HOUR_SLOTS) ? MaxSM : HOUR_SLOTS;
  localparam int unsigned CW  = $clog2(MaxD + 1);
  localparam int unsigned SIW = $clog2(SECOND_SLOTS);
  localparam int unsigned MIW = $clog2(MINUTE_SLOTS);
  localparam int unsigned HIW = $clog2(HOUR_SLOTS);

  logic [TW-1:0]  start_q, sbase_q, mbase_q, hbase_q, t_q;
  logic [tswc_pkg::DeltaW-1:0] delta_q;
  logic           late_s_q, late_m_q, late_h_q;
  logic [TW-1:0]  em_q, eh_q, ks_q, km_q, kh_q;
  logic [TW-1:0]  dn_q, e_sel, recip_sel, q_cur, rem_cur;
  logic [2*TW-1:0] prod_q;
  logic [CW-1:0]  cnt_q, m_q, m_cur;
  logic [CNW-1:0] spill_q;
  logic [CNW-1:0] mt_q, ht_q, dt_q;
  logic           ooo_q;
  logic [TW-1:0]  k_cur, d_cur;
  logic           k_big;

  tswc_pkg::ring_cmd_t rc_s, rc_m, rc_h;
  logic [SIW-1:0] off_s, rot_s;
  logic [MIW-1:0] off_m, rot_m;
  logic [HIW-1:0] off_h, rot_h;
  logic [CNW-1:0] wd_s, wd_m, wd_h, rd_s, rd_m, rd_h, tot_s, tot_m, tot_h, rd_cur;

  // divide by 60 or 3600: product registered first, quotient and remainder in the next cycle
  always_comb begin
    if (cmd_i.tier == tswc_pkg::TierHr) begin
      e_sel     = eh_q;
      recip_sel = tswc_pkg::RecipHour;
      q_cur     = TW'(prod_q >> tswc_pkg::ShiftHour);
      rem_cur   = dn_q - q_cur * tswc_pkg::SecPerHour;
    end else begin
      e_sel     = em_q;
      recip_sel = tswc_pkg::RecipMin;
      q_cur     = TW'(prod_q >> tswc_pkg::ShiftMin);
      rem_cur   = dn_q - q_cur * tswc_pkg::SecPerMin;
    end
  end

  always_comb begin
    unique case (cmd_i.tier)
      tswc_pkg::TierSec: begin k_cur = ks_q; d_cur = TW'(SECOND_SLOTS); rd_cur = rd_s; end
      tswc_pkg::TierMin: begin k_cur = km_q; d_cur = TW'(MINUTE_SLOTS); rd_cur = rd_m; end
      default:           begin k_cur = kh_q; d_cur = TW'(HOUR_SLOTS);   rd_cur = rd_h; end
    endcase
    k_big = (k_cur >= d_cur);
    m_cur = k_big ? d_cur[CW-1:0] : k_cur[CW-1:0];
  end

  assign stat_o.k_zero   = (k_cur == '0);
  assign stat_o.cnt_last = (({1'b0, cnt_q} + 1'b1) == {1'b0, m_q});

  // ring commands
  always_comb begin
    logic is_s, is_m, is_h;
    is_s = (cmd_i.tier == tswc_pkg::TierSec);
    is_m = (cmd_i.tier == tswc_pkg::TierMin);
    is_h = (cmd_i.tier == tswc_pkg::TierHr);

    rc_s.rd  = (cmd_i.clr_rd && is_s) || cmd_i.dl_rd;
    rc_s.wr  = (cmd_i.clr_wr && is_s) || cmd_i.dl_wr;
    rc_s.rot = cmd_i.age_init && is_s && !k_big;
    rc_m.rd  = (cmd_i.clr_rd && is_m) || (cmd_i.sp_rd && is_s);
    rc_m.wr  = (cmd_i.clr_wr && is_m) || (cmd_i.sp_wr && is_s);
    rc_m.rot = cmd_i.age_init && is_m && !k_big;
    rc_h.rd  = (cmd_i.clr_rd && is_h) || (cmd_i.sp_rd && is_m);
    rc_h.wr  = (cmd_i.clr_wr && is_h) || (cmd_i.sp_wr && is_m);
    rc_h.rot = cmd_i.age_init && is_h && !k_big;

    off_s = (cmd_i.clr_rd && is_s) ? cnt_q[SIW-1:0] : '0;
    off_m = (cmd_i.clr_rd && is_m) ? cnt_q[MIW-1:0] : '0;
    off_h = (cmd_i.clr_rd && is_h) ? cnt_q[HIW-1:0] : '0;
    rot_s = k_cur[SIW-1:0];
    rot_m = k_cur[MIW-1:0];
    rot_h = k_cur[HIW-1:0];

    wd_s = cmd_i.dl_wr ? rd_s + CNW'(delta_q) : '0;
    wd_m = cmd_i.sp_wr ? rd_m + spill_q : '0;
    wd_h = cmd_i.sp_wr ? rd_h + spill_q : '0;
  end

  tswc_ring #(.D(SECOND_SLOTS)) u_ring_s (
    .clk_i, .rst_ni, .cmd_i(rc_s), .off_i(off_s), .rot_i(rot_s),
    .wdata_i(wd_s), .rdata_o(rd_s), .total_o(tot_s)
  );
  tswc_ring #(.D(MINUTE_SLOTS)) u_ring_m (
    .clk_i, .rst_ni, .cmd_i(rc_m), .off_i(off_m), .rot_i(rot_m),
    .wdata_i(wd_m), .rdata_o(rd_m), .total_o(tot_m)
  );
  tswc_ring #(.D(HOUR_SLOTS)) u_ring_h (
    .clk_i, .rst_ni, .cmd_i(rc_h), .off_i(off_h), .rot_i(rot_h),
    .wdata_i(wd_h), .rdata_o(rd_h), .total_o(tot_h)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      sbase_q  <= '0;
      mbase_q  <= '0;
      hbase_q  <= '0;
      late_s_q <= 1'b0;
      late_m_q <= 1'b0;
      late_h_q <= 1'b0;
      cnt_q    <= '0;
      m_q      <= '0;
    end else begin
      if (cfg_i.we) begin
        start_q <= cfg_i.wdata;
        sbase_q <= cfg_i.wdata;
        mbase_q <= cfg_i.wdata;
        hbase_q <= cfg_i.wdata;
      end
      if (cmd_i.ld) begin
        late_s_q <= (timestamp_sec_i < sbase_q);
        late_m_q <= (timestamp_sec_i < mbase_q);
        late_h_q <= (timestamp_sec_i < hbase_q);
        if (timestamp_sec_i >= sbase_q) begin
          sbase_q <= timestamp_sec_i;
        end
      end
      if (cmd_i.div_step) begin
        if (cmd_i.tier == tswc_pkg::TierHr) begin
          if (!late_h_q) hbase_q <= t_q - rem_cur;
        end else begin
          if (!late_m_q) mbase_q <= t_q - rem_cur;
        end
      end
      if (cmd_i.age_init) begin
        cnt_q <= '0;
        m_q   <= m_cur;
      end else if (cmd_i.clr_wr) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // payload, divider, spill and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      t_q     <= timestamp_sec_i;
      delta_q <= delta_i;
      em_q    <= timestamp_sec_i - mbase_q;
      eh_q    <= timestamp_sec_i - hbase_q;
      ks_q    <= (timestamp_sec_i < sbase_q) ? '0 : timestamp_sec_i - sbase_q;
    end
    if (cmd_i.div_ld) begin
      dn_q   <= e_sel;
      prod_q <= (2*TW)'(e_sel) * (2*TW)'(recip_sel);
    end
    if (cmd_i.div_step) begin
      if (cmd_i.tier == tswc_pkg::TierHr) begin
        kh_q <= late_h_q ? '0 : q_cur;
      end else begin
        km_q <= late_m_q ? '0 : q_cur;
      end
    end
    if (cmd_i.age_init) begin
      spill_q <= '0;
    end else if (cmd_i.clr_wr) begin
      spill_q <= spill_q + rd_cur;
    end
    if (cmd_i.out_ld) begin
      mt_q  <= tot_s;
      ht_q  <= tot_m;
      dt_q  <= tot_h;
      ooo_q <= late_s_q || late_m_q || late_h_q;
    end
  end

  assign start_time_o   = start_q;
  assign minute_total_o = mt_q;
  assign hour_total_o   = ht_q;
  assign day_total_o    = dt_q;
  assign out_of_order_o = ooo_q;

endmodule

### sv/tswc_ctrl.sv
// Sequencer: steps the divider, ring ageing, spill, delta add and output load.
// Depends on tswc_pkg.
module tswc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tswc_pkg::ctrl_cmd_t  cmd_o,
  input  tswc_pkg::ctrl_stat_t stat_i
);

  tswc_pkg::state_e state_q, state_d;
  tswc_pkg::tier_e  tier_q, tier_d;
  logic             out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tswc_pkg::StIdle;
      tier_q      <= tswc_pkg::TierSec;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tier_q  <= tier_d;
      if (cmd_o.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    tier_d     = tier_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.tier = tier_q;
    unique case (state_q)
      tswc_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld = 1'b1;
          tier_d   = tswc_pkg::TierMin;
          state_d  = tswc_pkg::StDivLd;
        end
      end
      tswc_pkg::StDivLd: begin
        cmd_o.div_ld = 1'b1;
        state_d      = tswc_pkg::StDivRun;
      end
      tswc_pkg::StDivRun: begin
        cmd_o.div_step = 1'b1;
        if (tier_q == tswc_pkg::TierMin) begin
          tier_d  = tswc_pkg::TierHr;
          state_d = tswc_pkg::StDivLd;
        end else begin
          tier_d  = tswc_pkg::TierSec;
          state_d = tswc_pkg::StAgeInit;
        end
      end
      tswc_pkg::StAgeInit: begin
        cmd_o.age_init = 1'b1;
        state_d = stat_i.k_zero ? tswc_pkg::StNextTier : tswc_pkg::StClrRd;
      end
      tswc_pkg::StClrRd: begin
        cmd_o.clr_rd = 1'b1;
        state_d      = tswc_pkg::StClrWr;
      end
      tswc_pkg::StClrWr: begin
        cmd_o.clr_wr = 1'b1;
        if (!stat_i.cnt_last) begin
          state_d = tswc_pkg::StClrRd;
        end else if (tier_q == tswc_pkg::TierHr) begin
          state_d = tswc_pkg::StNextTier;   // hour spill is dropped
        end else begin
          state_d = tswc_pkg::StSpRd;
        end
      end
      tswc_pkg::StSpRd: begin
        cmd_o.sp_rd = 1'b1;
        state_d     = tswc_pkg::StSpWr;
      end
      tswc_pkg::StSpWr: begin
        cmd_o.sp_wr = 1'b1;
        state_d     = tswc_pkg::StNextTier;
      end
      tswc_pkg::StNextTier: begin
        unique case (tier_q)
          tswc_pkg::TierSec: begin
            tier_d  = tswc_pkg::TierMin;
            state_d = tswc_pkg::StAgeInit;
          end
          tswc_pkg::TierMin: begin
            tier_d  = tswc_pkg::TierHr;
            state_d = tswc_pkg::StAgeInit;
          end
          default: begin
            tier_d  = tswc_pkg::TierSec;
            state_d = tswc_pkg::StDlRd;
          end
        endcase
      end
      tswc_pkg::StDlRd: begin
        cmd_o.dl_rd = 1'b1;
        state_d     = tswc_pkg::StDlWr;
      end
      tswc_pkg::StDlWr: begin
        cmd_o.dl_wr = 1'b1;
        state_d     = tswc_pkg::StDone;
      end
      tswc_pkg::StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = tswc_pkg::StIdle;
        end
      end
      default: begin
        state_d = tswc_pkg::StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### sv/tiered_sliding_window_counter_top.sv
// Top level of the tiered sliding-window counter: APB register, controller, datapath.
// Depends on tswc_pkg, tswc_ctrl, tswc_datapath and the macros header.
//
//   channel  | handshake               | payload
//   in       | in_valid_i / in_ready_o | timestamp_sec_i, delta_i
//   out      | out_valid_o/out_ready_i | minute_total_o, hour_total_o, day_total_o,
//            |                         | out_of_order_o
//   config   | psel/penable/pwrite     | paddr, pwdata, prdata (start_time at 0x0)
//
// One word runs the divides by 60 and 3600, then per aged tier a read and a write of
// each of m slots, m = slots cleared in that tier (at most its depth), plus a spill
// read and write for an aged second or minute tier, then the delta add. The clearing
// loop, one slot memory access at a time, sets the run length.
// Reset empties the rings at once through per-slot valid bits; no clearing pass.
// A finished word waits in the output register while the next word is taken.
`include "tiered_sliding_window_counter_top_macros.svh"
module tiered_sliding_window_counter_top #(
  parameter int unsigned SECOND_SLOTS = 60,
  parameter int unsigned MINUTE_SLOTS = 60,
  parameter int unsigned HOUR_SLOTS   = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tswc_pkg::PAddrW-1:0]    paddr,
  input  logic [tswc_pkg::PDataW-1:0]    pwdata,
  output logic [tswc_pkg::PDataW-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tswc_pkg::TimeW-1:0]     timestamp_sec_i,
  input  logic [tswc_pkg::DeltaW-1:0]    delta_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tswc_pkg::CountW-1:0]    minute_total_o,
  output logic [tswc_pkg::CountW-1:0]    hour_total_o,
  output logic [tswc_pkg::CountW-1:0]    day_total_o,
  output logic                           out_of_order_o
);

  tswc_pkg::ctrl_cmd_t  cmd;
  tswc_pkg::ctrl_stat_t stat;
  tswc_pkg::cfg_wr_t    cfg;
  logic [tswc_pkg::TimeW-1:0] start_time;

  assign pready    = 1'b1;
  assign cfg.we    = psel && penable && pwrite && (paddr[2:2] == tswc_pkg::RegStartTime);
  assign cfg.wdata = pwdata;
  assign prdata    = (paddr[2:2] == tswc_pkg::RegStartTime) ? start_time : '0;

  tswc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .stat_i(stat)
  );

  tswc_datapath #(
    .SECOND_SLOTS(SECOND_SLOTS),
    .MINUTE_SLOTS(MINUTE_SLOTS),
    .HOUR_SLOTS(HOUR_SLOTS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .stat_o(stat),
    .cfg_i(cfg), .start_time_o(start_time),
    .timestamp_sec_i, .delta_i,
    .minute_total_o, .hour_total_o, .day_total_o, .out_of_order_o
  );

  // busy for the whole run once a word is taken
  `TSWC_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o)
  // a new result is only loaded from the end of a run
  `TSWC_ASSERT(a_result_from_run, $rose(out_valid_o) |-> $past(!in_ready_o))
  // at most one pipeline action per cycle on the rings
  `TSWC_ASSERT_ALWAYS(a_one_ring_op, $onehot0({cmd.clr_rd, cmd.clr_wr, cmd.sp_rd,
                                               cmd.sp_wr, cmd.dl_rd, cmd.dl_wr}))

endmodule

### sim/testbench.sv
// Self-checking testbench for the tiered sliding-window counter top level.
// Needs tswc_pkg and tiered_sliding_window_counter_top; predicts every output word.
`timescale 1ns / 100ps
module testbench;

  localparam int unsigned NSec = 60;
  localparam int unsigned NMin = 60;
  localparam int unsigned NHr  = 24;
  localparam int unsigned RandWords = 1200;

  typedef struct packed {
    logic [tswc_pkg::TimeW-1:0]  ts;
    logic [tswc_pkg::DeltaW-1:0] delta;
  } event_t;

  typedef struct packed {
    logic [tswc_pkg::CountW-1:0] minute_total;
    logic [tswc_pkg::CountW-1:0] hour_total;
    logic [tswc_pkg::CountW-1:0] day_total;
    logic                        out_of_order;
  } totals_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [tswc_pkg::PAddrW-1:0] paddr = '0;
  logic [tswc_pkg::PDataW-1:0] pwdata = '0;
  logic [tswc_pkg::PDataW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [tswc_pkg::TimeW-1:0] timestamp_sec_i = '0;
  logic [tswc_pkg::DeltaW-1:0] delta_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [tswc_pkg::CountW-1:0] minute_total_o, hour_total_o, day_total_o;
  logic out_of_order_o;

  tiered_sliding_window_counter_top u_top (.*);

  // predictor state
  logic [31:0] sec_ring [NSec];
  logic [31:0] min_ring [NMin];
  logic [31:0] hr_ring  [NHr];
  logic [31:0] sec_base, min_base, hr_base;

  event_t  pending_events[$];
  totals_t expected_totals[$];
  int      n_errors = 0;
  int      in_gap = 0, out_gap = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 400);
  endfunction

  function automatic logic [31:0] shift_ring(ref logic [31:0] ring [], input int depth,
                                             input logic [31:0] k);
    logic [31:0] spill;
    spill = '0;
    if (k == 0) return '0;
    for (int i = depth - 1; i >= 0; i--) begin
      if (k >= depth || i + k >= depth) spill += ring[i];
      else ring[i + k] = ring[i];
    end
    for (int i = 0; i < depth; i++)
      if (i < k) ring[i] = '0;
    return spill;
  endfunction

  task automatic set_start_time(input logic [31:0] value);
    sec_base = value;
    min_base = value;
    hr_base  = value;
  endtask

  task automatic predict_totals(input event_t ev);
    logic [31:0] e, sp;
    logic [31:0] dyn_s [], dyn_m [], dyn_h [];
    totals_t r;
    dyn_s = new[NSec];
    dyn_m = new[NMin];
    dyn_h = new[NHr];
    foreach (sec_ring[i]) dyn_s[i] = sec_ring[i];
    foreach (min_ring[i]) dyn_m[i] = min_ring[i];
    foreach (hr_ring[i])  dyn_h[i] = hr_ring[i];
    r = '0;
    if (ev.ts < sec_base) r.out_of_order = 1'b1;
    else begin
      sp = shift_ring(dyn_s, NSec, ev.ts - sec_base);
      dyn_m[0] += sp;
      sec_base = ev.ts;
    end
    if (ev.ts < min_base) r.out_of_order = 1'b1;
    else begin
      e = ev.ts - min_base;
      sp = shift_ring(dyn_m, NMin, e / 60);
      dyn_h[0] += sp;
      min_base = ev.ts - (e % 60);
    end
    if (ev.ts < hr_base) r.out_of_order = 1'b1;
    else begin
      e = ev.ts - hr_base;
      sp = shift_ring(dyn_h, NHr, e / 3600);
      hr_base = ev.ts - (e % 3600);
    end
    dyn_s[0] += ev.delta;
    foreach (sec_ring[i]) begin sec_ring[i] = dyn_s[i]; r.minute_total += dyn_s[i]; end
    foreach (min_ring[i]) begin min_ring[i] = dyn_m[i]; r.hour_total += dyn_m[i]; end
    foreach (hr_ring[i])  begin hr_ring[i]  = dyn_h[i]; r.day_total += dyn_h[i]; end
    expected_totals.push_back(r);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_totals('{timestamp_sec_i, delta_i});
        void'(pending_events.pop_front());
        in_gap <= gap_len();
        if (pending_events.size() > 0 && gap_len() == 0) begin
          timestamp_sec_i <= pending_events[0].ts;
          delta_i         <= pending_events[0].delta;
        end else
          in_valid_i <= 1'b0;
      end else if (!in_valid_i && pending_events.size() > 0) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        else begin
          in_valid_i      <= 1'b1;
          timestamp_sec_i <= pending_events[0].ts;
          delta_i         <= pending_events[0].delta;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i) begin
    totals_t exp_t;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_totals.size() == 0) begin
          $error("unexpected output word");
          n_errors++;
        end else begin
          exp_t = expected_totals.pop_front();
          if (minute_total_o !== exp_t.minute_total) begin
            $error("minute_total exp %0d got %0d", exp_t.minute_total, minute_total_o);
            n_errors++;
          end
          if (hour_total_o !== exp_t.hour_total) begin
            $error("hour_total exp %0d got %0d", exp_t.hour_total, hour_total_o);
            n_errors++;
          end
          if (day_total_o !== exp_t.day_total) begin
            $error("day_total exp %0d got %0d", exp_t.day_total, day_total_o);
            n_errors++;
          end
          if (out_of_order_o !== exp_t.out_of_order) begin
            $error("out_of_order exp %0d got %0d", exp_t.out_of_order, out_of_order_o);
            n_errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (out_ready_i && out_valid_o) begin
        out_gap <= gap_len();
        out_ready_i <= 1'b0;
      end else
        out_ready_i <= 1'b1;
    end
  end

  task automatic apb_write(input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; pwdata <= value;
    paddr <= tswc_pkg::PAddrW'(tswc_pkg::RegStartTime) << 2;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    set_start_time(value);
  endtask

  task automatic drain();
    while (pending_events.size() > 0 || in_valid_i || expected_totals.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic add_event(input logic [31:0] ts, input logic [15:0] d);
    pending_events.push_back('{ts, d});
  endtask

  // random run of mostly rising timestamps from base, some late ones
  task automatic random_phase(input logic [31:0] base, input int n);
    logic [31:0] t;
    int r;
    t = base;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      t += $urandom_range(0, 3);
      else if (r < 65) t += $urandom_range(0, 120);
      else if (r < 80) t += $urandom_range(0, 8000);
      else if (r < 88) t += $urandom_range(0, 200000);
      if (r >= 94) add_event(t - $urandom_range(1, 5000), $urandom);
      else add_event(t, ($urandom_range(0, 9) == 0) ? 16'hFFFF :
                        ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom));
    end
  endtask

  initial begin
    foreach (sec_ring[i]) sec_ring[i] = '0;
    foreach (min_ring[i]) min_ring[i] = '0;
    foreach (hr_ring[i])  hr_ring[i]  = '0;
    set_start_time('0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_write(32'd0);
    // directed: extremes of delta, shifts of one slot, exact ring lengths, late word
    add_event(0, 16'hFFFF);
    add_event(0, 0);
    add_event(1, 16'h5555);
    add_event(59, 16'hAAAA);
    add_event(60, 1);
    add_event(3599, 2);
    add_event(3600, 3);
    add_event(3600 * 24, 4);
    add_event(3600 * 24 + 1, 5);
    add_event(100, 6);
    add_event(3600 * 50, 16'hFFFF);
    add_event(3600 * 50 + 61, 16'h8000);
    drain();
    apb_write(32'hFFFF_FFF0);
    add_event(32'hFFFF_FFF0, 16'hFFFF);
    add_event(32'hFFFF_FFFF, 16'h0001);
    add_event(32'h0000_0000, 16'h1234);
    drain();
    apb_write(32'h8000_0000);
    add_event(32'h7FFF_FFFF, 7);
    drain();
    apb_write(32'd1000);
    random_phase(32'd1000, RandWords / 3);
    drain();
    apb_write(32'h5555_AAAA);
    random_phase(32'h5555_AAAA, RandWords / 3);
    drain();
    apb_write(32'h0000_0000);
    random_phase(32'h0000_0000, RandWords / 3);
    drain();
    if (n_errors == 0 && expected_totals.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
